>>> design/mclp_pkg.sv
// shared types, constants and match helpers for the motor command line parser
// used by every module of the block; no dependencies
package mclp_pkg;

  localparam int LINE_DEPTH_DEF = 16;
  // longest command, TEMPLIMIT:ddd.d
  localparam int CMD_LEN_MAX    = 15;
  localparam int TEXT_IDX_W     = $clog2(CMD_LEN_MAX);
  localparam int PAT_W          = CMD_LEN_MAX * 8;

  localparam logic [7:0] BYTE_CR    = 8'd13;
  localparam logic [7:0] CHAR_DIGIT = "#";

  // step count = deg * 12 / 45 = floor(deg * 4 * 4370 / 2^16) for deg < 1000
  localparam logic [14:0] STEP_RECIP = 15'd17480;
  localparam int          STEP_SHIFT = 16;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_RPS       = 3'd1,
    CMD_DIR       = 3'd2,
    CMD_MOTOR_ON  = 3'd3,
    CMD_MOTOR_OFF = 3'd4,
    CMD_STEP      = 3'd5,
    CMD_TEMP      = 3'd6
  } cmd_t;

  // patterns padded with spaces, first character in the top byte
  localparam logic [PAT_W-1:0] PAT_RPS      = "RPS:##.#       ";
  localparam logic [PAT_W-1:0] PAT_DIR_CW   = "DIR:CW         ";
  localparam logic [PAT_W-1:0] PAT_DIR_CCW  = "DIR:CCW        ";
  localparam logic [PAT_W-1:0] PAT_MOTOR_ON = "MOTOR:ON       ";
  localparam logic [PAT_W-1:0] PAT_MOTOR_OF = "MOTOR:OFF      ";
  localparam logic [PAT_W-1:0] PAT_STEP_CW  = "STEPCW:###     ";
  localparam logic [PAT_W-1:0] PAT_STEP_CCW = "STEPCCW:###    ";
  localparam logic [PAT_W-1:0] PAT_TEMP     = "TEMPLIMIT:###.#";

  typedef logic [CMD_LEN_MAX-1:0][7:0] text_t;

  // current line as seen by the decoder
  typedef struct packed {
    text_t                 text;
    logic [TEXT_IDX_W-1:0] len;
    logic                  fits;  // no overflow and length within CMD_LEN_MAX
  } line_t;

  // decoder verdict for the buffered line
  typedef struct packed {
    cmd_t        cmd;
    logic [13:0] val;
    logic [8:0]  steps;
    logic        rps;
    logic        dir_cw;
    logic        dir_ccw;
    logic        motor_on;
    logic        motor_stop;
    logic        step_cw;
    logic        step_ccw;
    logic        temp;
  } dec_t;

  function automatic logic is_digit(logic [7:0] b);
    is_digit = (b >= "0") && (b <= "9");
  endfunction

  function automatic logic line_match(line_t ln, logic [PAT_W-1:0] pat,
                                      logic [TEXT_IDX_W-1:0] plen);
    logic       ok;
    logic [7:0] pc;
    ok = ln.fits && (ln.len == plen);
    for (int i = 0; i < CMD_LEN_MAX; i++) begin
      pc = pat[(CMD_LEN_MAX-1-i)*8 +: 8];
      if (TEXT_IDX_W'(i) < plen) begin
        if (pc == CHAR_DIGIT) begin
          ok = ok && is_digit(ln.text[i]);
        end else begin
          ok = ok && (ln.text[i] == pc);
        end
      end
    end
    line_match = ok;
  endfunction

endpackage

>>> design/mclp_line_buf.sv
// line buffer: collects received bytes until carriage return, tracks length and overflow
// depends on mclp_pkg
module mclp_line_buf #(
  parameter int LINE_DEPTH = mclp_pkg::LINE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,    // accepted byte that is not a carriage return
  input  logic [7:0]      wr_byte,
  input  logic            clr,      // accepted carriage return
  output mclp_pkg::line_t line
);

  localparam int LEN_W = $clog2(LINE_DEPTH + 1);

  mclp_pkg::text_t text_r;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             ovf_r, ovf_nxt;

  // only the first CMD_LEN_MAX bytes can ever match a command
  always_ff @(posedge clk) begin
    if (wr_en && (len_r < LEN_W'(mclp_pkg::CMD_LEN_MAX))) begin
      text_r[len_r[mclp_pkg::TEXT_IDX_W-1:0]] <= wr_byte;
    end
  end

  always_comb begin
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    priority if (clr) begin
      len_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (wr_en) begin
      if (len_r < LEN_W'(LINE_DEPTH)) begin
        len_nxt = len_r + LEN_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end else begin
      len_nxt = len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      len_r <= len_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign line.text = text_r;
  assign line.len  = len_r[mclp_pkg::TEXT_IDX_W-1:0];
  assign line.fits = !ovf_r && (len_r <= LEN_W'(mclp_pkg::CMD_LEN_MAX));

endmodule

>>> design/mclp_decode.sv
// command decoder: matches the buffered line against the command set and
// converts the decimal fields; depends on mclp_pkg
module mclp_decode (
  input  mclp_pkg::line_t line,
  output mclp_pkg::dec_t  dec
);

  logic        m_rps, m_cw, m_ccw, m_on, m_off, m_scw, m_sccw, m_temp;
  logic [3:0]  dh, dt, du;
  logic [9:0]  rps_val, deg;
  logic [13:0] temp_val;
  logic [24:0] step_prod;

  assign m_rps  = mclp_pkg::line_match(line, mclp_pkg::PAT_RPS,      4'd8);
  assign m_cw   = mclp_pkg::line_match(line, mclp_pkg::PAT_DIR_CW,   4'd6);
  assign m_ccw  = mclp_pkg::line_match(line, mclp_pkg::PAT_DIR_CCW,  4'd7);
  assign m_on   = mclp_pkg::line_match(line, mclp_pkg::PAT_MOTOR_ON, 4'd8);
  assign m_off  = mclp_pkg::line_match(line, mclp_pkg::PAT_MOTOR_OF, 4'd9);
  assign m_scw  = mclp_pkg::line_match(line, mclp_pkg::PAT_STEP_CW,  4'd10);
  assign m_sccw = mclp_pkg::line_match(line, mclp_pkg::PAT_STEP_CCW, 4'd11);
  assign m_temp = mclp_pkg::line_match(line, mclp_pkg::PAT_TEMP,     4'd15);

  // ascii digits carry their value in the low nibble
  assign rps_val = 10'(line.text[4][3:0]) * 10'd100 + 10'(line.text[5][3:0]) * 10'd10
                 + 10'(line.text[7][3:0]);

  assign temp_val = 14'(line.text[10][3:0]) * 14'd1000 + 14'(line.text[11][3:0]) * 14'd100
                  + 14'(line.text[12][3:0]) * 14'd10 + 14'(line.text[14][3:0]);

  // degree digits start one place later for the counterclockwise form
  assign dh = m_sccw ? line.text[8][3:0]  : line.text[7][3:0];
  assign dt = m_sccw ? line.text[9][3:0]  : line.text[8][3:0];
  assign du = m_sccw ? line.text[10][3:0] : line.text[9][3:0];

  assign deg       = 10'(dh) * 10'd100 + 10'(dt) * 10'd10 + 10'(du);
  assign step_prod = 25'(deg) * 25'(mclp_pkg::STEP_RECIP);

  always_comb begin
    dec            = '0;
    dec.rps        = m_rps;
    dec.dir_cw     = m_cw;
    dec.dir_ccw    = m_ccw;
    dec.motor_on   = m_on;
    dec.motor_stop = m_off;
    dec.step_cw    = m_scw;
    dec.step_ccw   = m_sccw;
    dec.temp       = m_temp;
    dec.steps      = step_prod[mclp_pkg::STEP_SHIFT +: 9];
    priority if (m_rps) begin
      dec.cmd = mclp_pkg::CMD_RPS;
      dec.val = 14'(rps_val);
    end else if (m_cw || m_ccw) begin
      dec.cmd = mclp_pkg::CMD_DIR;
    end else if (m_on) begin
      dec.cmd = mclp_pkg::CMD_MOTOR_ON;
    end else if (m_off) begin
      dec.cmd = mclp_pkg::CMD_MOTOR_OFF;
    end else if (m_scw || m_sccw) begin
      dec.cmd = mclp_pkg::CMD_STEP;
      dec.val = 14'(deg);
    end else if (m_temp) begin
      dec.cmd = mclp_pkg::CMD_TEMP;
      dec.val = temp_val;
    end else begin
      dec.cmd = mclp_pkg::CMD_NONE;
      dec.val = '0;
    end
  end

endmodule

>>> design/motor_command_line_parser.sv
// top level of the motor command line parser: handshake, motor state and result register
// depends on mclp_pkg, mclp_line_buf and mclp_decode
//
// Takes one received byte per request on the in_ stream, one per clock when the
// out_ side keeps up. Bytes other than carriage return only fill the line buffer
// and produce nothing. A carriage return is decoded in the same cycle straight
// from the line buffer registers and its single result sits in the out_ register
// from the next cycle on. The input is stalled only while a finished result is
// held by out_tready low; a line is rejected (accepted bit 0, command 0) when it
// is malformed, unknown or longer than LINE_DEPTH bytes, and then leaves the
// motor state untouched.
module motor_command_line_parser #(
  parameter int LINE_DEPTH = mclp_pkg::LINE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] line_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // accepted, parsed_value, step_count, turn_direction,
                                  // motor_running, motor_start, step_pending, rate_set,
                                  // show_default_rate, temp_ceiling, zero pad
  output logic [2:0]  out_tuser   // [2:0] command
);

  mclp_pkg::line_t line;
  mclp_pkg::dec_t  dec;

  logic in_acc, is_cr, cr_acc;

  logic       dir_r, dir_nxt;
  logic       motor_r, motor_nxt;
  logic       stepf_r, stepf_nxt;
  logic       ratef_r, ratef_nxt;
  logic       dflt_r, dflt_nxt;
  logic [8:0]  steps_r, steps_nxt;
  logic [13:0] temp_r, temp_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [47:0] out_data_r, out_data_nxt;
  logic [2:0]  out_user_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign is_cr     = (in_tdata == mclp_pkg::BYTE_CR);
  assign cr_acc    = in_acc && is_cr;

  mclp_line_buf #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_line_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (in_acc && !is_cr),
    .wr_byte(in_tdata),
    .clr    (cr_acc),
    .line   (line)
  );

  mclp_decode u_decode (
    .line(line),
    .dec (dec)
  );

  always_comb begin
    dir_nxt   = dir_r;
    motor_nxt = motor_r;
    stepf_nxt = stepf_r;
    ratef_nxt = ratef_r;
    dflt_nxt  = dflt_r;
    steps_nxt = steps_r;
    temp_nxt  = temp_r;
    if (dec.rps) begin
      ratef_nxt = 1'b1;
      dflt_nxt  = 1'b0;
    end
    if (dec.dir_cw || dec.step_ccw) begin
      dir_nxt = 1'b0;
    end
    if (dec.dir_ccw || dec.step_cw) begin
      dir_nxt = 1'b1;
    end
    if (dec.motor_on) begin
      motor_nxt = 1'b1;
      dflt_nxt  = 1'b0;
    end
    if (dec.motor_stop) begin
      motor_nxt = 1'b0;
      dflt_nxt  = 1'b1;
    end
    if (dec.step_cw || dec.step_ccw) begin
      stepf_nxt = 1'b1;
      steps_nxt = dec.steps;
    end
    if (dec.temp) begin
      temp_nxt = dec.val;
    end
  end

  assign out_data_nxt = {4'b0, temp_nxt, dflt_nxt, ratef_nxt, stepf_nxt, dec.motor_on,
                         motor_nxt, dir_nxt, steps_nxt, dec.val,
                         (dec.cmd != mclp_pkg::CMD_NONE)};

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cr_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r       <= 1'b0;
      motor_r     <= 1'b0;
      stepf_r     <= 1'b0;
      ratef_r     <= 1'b0;
      dflt_r      <= 1'b1;
      steps_r     <= '0;
      temp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cr_acc) begin
        dir_r   <= dir_nxt;
        motor_r <= motor_nxt;
        stepf_r <= stepf_nxt;
        ratef_r <= ratef_nxt;
        dflt_r  <= dflt_nxt;
        steps_r <= steps_nxt;
        temp_r  <= temp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cr_acc) begin
      out_data_r <= out_data_nxt;
      out_user_r <= dec.cmd;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

>>> design/mclp_checker.sv
// port-level checker for the motor command line parser, bound to the top level
// depends on mclp_pkg and motor_command_line_parser
module mclp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // accepted bit agrees with the command code
  a_acc_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tuser != mclp_pkg::CMD_NONE)))
    else $error("accepted flag and command disagree");

  // start pulse only with an accepted motor on
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[26] |-> out_tuser == mclp_pkg::CMD_MOTOR_ON)
    else $error("motor start without motor on");

  // a new result follows a carriage return request
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tdata == mclp_pkg::BYTE_CR))
    else $error("result without carriage return");

  // rejected lines report no value
  a_rej_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[14:1] == 14'd0 && !out_tdata[26])
    else $error("rejected line carries a value");

endmodule

bind motor_command_line_parser mclp_checker u_mclp_checker (.*);
